### rtl/rbb_pkg.sv
// Shared types, widths and constants of the rotated box bounds block.
`timescale 1ns / 1ps
package rbb_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int ANGLE_FRAC_BITS = 4;
    localparam int SINE_BITS       = 16;

    localparam int POS_W   = 21;
    localparam int ANGLE_W = 16;
    localparam int OFS_W   = 20;
    localparam int SIZE_W  = 16;
    localparam int DIM_W   = 20;
    localparam int CEN_W   = 23;
    localparam int CRN_W   = 19;

    localparam int IN_W       = 2 * POS_W + ANGLE_W;
    localparam int S_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = OFS_W;

    // pipeline stages
    localparam int NSTAGE  = 10;
    localparam int ST_ACC  = 0;
    localparam int ST_REM  = 1;
    localparam int ST_QUAD = 2;
    localparam int ST_ROM  = 3;
    localparam int ST_SC   = 4;
    localparam int ST_MUL  = 5;
    localparam int ST_CRN  = 6;
    localparam int ST_MM   = 7;
    localparam int ST_SUM  = 8;
    localparam int ST_OUT  = 9;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    // (2n)(2n+1) for the sine series terms
    localparam longint unsigned TAYLOR_DIV [13] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_X,
        CFG_OFFSET_Y,
        CFG_SIZE_X,
        CFG_SIZE_Y
    } cfg_index_t;

    typedef struct packed {
        logic [NSTAGE-1:0] en;
        logic [NSTAGE-1:0] vld;
    } pipe_ctrl_t;

    typedef struct packed {
        logic signed [CRN_W-1:0] corner3_y;
        logic signed [CRN_W-1:0] corner3_x;
        logic signed [CRN_W-1:0] corner2_y;
        logic signed [CRN_W-1:0] corner2_x;
        logic signed [CRN_W-1:0] corner1_y;
        logic signed [CRN_W-1:0] corner1_x;
        logic signed [CRN_W-1:0] corner0_y;
        logic signed [CRN_W-1:0] corner0_x;
        logic signed [CEN_W-1:0] center_y;
        logic signed [CEN_W-1:0] center_x;
        logic [DIM_W-1:0]        box_height;
        logic [DIM_W-1:0]        box_width;
    } result_t;

    localparam int RES_W     = $bits(result_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

### rtl/rotated_box_bounds_core.sv
// Top level of the rotated box bounds block.
//
// Input stream (s_axis): one word per object, position and rotation angle.
// Output stream (m_axis): one word per input word, in order: bounding box
// width, height and centre, and the four rotated corners in whole pixels.
// Configuration channel (cfg_*): writes offset and size registers, always
// ready; write only while no word is in flight.
// A word passes through all ten register stages before its result is shown on
// m_axis. Throughput: one word per cycle while the receiver takes words; the
// ten register stages (angle reduction, two-port sine table read, four
// multipliers, corner sums, min/max, rounding) each have their own load enable.
// Reset clears every stage's valid bit and the configuration registers to
// zero; the table is constant and needs no fill.
// When the receiver stalls the output word holds, upstream stages keep
// filling empty slots, and s_axis_tready drops only when all ten stages
// hold words.
`timescale 1ns / 1ps
module rotated_box_bounds_core
#(
    parameter int COORD_FRAC_BITS = rbb_pkg::COORD_FRAC_BITS,
    parameter int ANGLE_FRAC_BITS = rbb_pkg::ANGLE_FRAC_BITS,
    parameter int SINE_BITS       = rbb_pkg::SINE_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // pos_x, pos_y, angle
    input  logic [rbb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // box_width, box_height, center_x, center_y, corner0_x, corner0_y,
    // corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
    output logic [rbb_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PW = rbb_pkg::POS_W;
    localparam int AW = rbb_pkg::ANGLE_W;

    logic signed [rbb_pkg::OFS_W-1:0] offset_x_reg;
    logic signed [rbb_pkg::OFS_W-1:0] offset_y_reg;
    logic [rbb_pkg::SIZE_W-1:0]       size_x_reg;
    logic [rbb_pkg::SIZE_W-1:0]       size_y_reg;
    rbb_pkg::pipe_ctrl_t              ctrl;
    logic signed [SINE_BITS:0]        sin_val;
    logic signed [SINE_BITS:0]        cos_val;
    rbb_pkg::result_t                 res;
    logic signed [PW-1:0]             pos_x;
    logic signed [PW-1:0]             pos_y;
    logic signed [AW-1:0]             angle;

    assign pos_x = $signed(s_axis_tdata[PW-1:0]);
    assign pos_y = $signed(s_axis_tdata[2*PW-1:PW]);
    assign angle = $signed(s_axis_tdata[2*PW+AW-1:2*PW]);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            size_x_reg   <= '0;
            size_y_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (rbb_pkg::cfg_index_t'(cfg_index))
                rbb_pkg::CFG_OFFSET_X: offset_x_reg <= $signed(cfg_data);
                rbb_pkg::CFG_OFFSET_Y: offset_y_reg <= $signed(cfg_data);
                rbb_pkg::CFG_SIZE_X:   size_x_reg   <= cfg_data[rbb_pkg::SIZE_W-1:0];
                rbb_pkg::CFG_SIZE_Y:   size_y_reg   <= cfg_data[rbb_pkg::SIZE_W-1:0];
                default:               offset_x_reg <= offset_x_reg;
            endcase
        end
    end

    rbb_pipe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .ctrl      (ctrl)
    );

    rbb_angle
    #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .SINE_BITS       (SINE_BITS)
    )
    u_angle
    (
        .clk     (clk),
        .ctrl    (ctrl),
        .angle   (angle),
        .sin_val (sin_val),
        .cos_val (cos_val)
    );

    rbb_geom
    #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .SINE_BITS       (SINE_BITS)
    )
    u_geom
    (
        .clk      (clk),
        .ctrl     (ctrl),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .offset_x (offset_x_reg),
        .offset_y (offset_y_reg),
        .size_x   (size_x_reg),
        .size_y   (size_y_reg),
        .sin_val  (sin_val),
        .cos_val  (cos_val),
        .res      (res)
    );

    assign m_axis_tvalid = ctrl.vld[rbb_pkg::NSTAGE-1];
    assign m_axis_tdata  = rbb_pkg::M_TDATA_W'(res);

endmodule

### rtl/rbb_pipe_ctrl.sv
// Valid bits and per-stage load enables of the box pipeline.
`timescale 1ns / 1ps
module rbb_pipe_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output rbb_pkg::pipe_ctrl_t ctrl
);

    localparam int N = rbb_pkg::NSTAGE;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N-1:0] en;

    // a stage loads when it is empty or its word moves on
    always_comb
    begin
        en[N-1] = !vld_reg[N-1] || out_ready;
        for (int i = N - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < N; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready = en[0];
    assign ctrl.en  = en;
    assign ctrl.vld = vld_reg;

endmodule

### rtl/rbb_sine_rom.sv
// Quarter-wave sine table with two registered read ports.
`timescale 1ns / 1ps
module rbb_sine_rom
#(
    parameter int ANGLE_FRAC_BITS = rbb_pkg::ANGLE_FRAC_BITS,
    parameter int SINE_BITS       = rbb_pkg::SINE_BITS
)
(
    input  logic                                         clk,
    input  logic                                         en,
    input  logic [$clog2((90 << ANGLE_FRAC_BITS) + 1)-1:0] addr_a,
    input  logic [$clog2((90 << ANGLE_FRAC_BITS) + 1)-1:0] addr_b,
    output logic [SINE_BITS-1:0]                         data_a,
    output logic [SINE_BITS-1:0]                         data_b
);

    localparam int          QUARTER = 90 << ANGLE_FRAC_BITS;
    localparam int          DEPTH   = QUARTER + 1;
    localparam int          SFRAC   = SINE_BITS - 1;
    localparam logic [63:0] STEP    = rbb_pkg::PI_Q60 / 64'(180 << ANGLE_FRAC_BITS);
    localparam logic [63:0] ONE     = 64'd1 << SFRAC;

    // sin(k step) in Q60 by series, rounded to SFRAC fraction bits
    function automatic logic [SINE_BITS-1:0] sin_entry(input int k);
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  t;
        logic [63:0]  s;
        logic [63:0]  e;
        logic [127:0] p;
        x  = STEP * 64'(k);
        p  = {64'd0, x} * {64'd0, x};
        x2 = p[123:60];
        t  = x;
        s  = x;
        for (int n = 0; n < 13; n++)
        begin
            p = {64'd0, t} * {64'd0, x2};
            t = p[123:60] / rbb_pkg::TAYLOR_DIV[n];
            if (n % 2 == 0)
            begin
                s = s - t;
            end
            else
            begin
                s = s + t;
            end
        end
        e = (s + (64'd1 << (59 - SFRAC))) >> (60 - SFRAC);
        if (e > ONE)
        begin
            e = ONE;
        end
        return e[SINE_BITS-1:0];
    endfunction

    logic [SINE_BITS-1:0] rom [DEPTH];

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_entry
        assign rom[g] = sin_entry(g);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a <= rom[addr_a];
            data_b <= rom[addr_b];
        end
    end

endmodule

### rtl/rbb_angle.sv
// Angle reduction, quadrant split and sine/cosine lookup.
`timescale 1ns / 1ps
module rbb_angle
#(
    parameter int ANGLE_FRAC_BITS = rbb_pkg::ANGLE_FRAC_BITS,
    parameter int SINE_BITS       = rbb_pkg::SINE_BITS
)
(
    input  logic                               clk,
    input  rbb_pkg::pipe_ctrl_t                ctrl,
    input  logic signed [rbb_pkg::ANGLE_W-1:0] angle,
    output logic signed [SINE_BITS:0]          sin_val,
    output logic signed [SINE_BITS:0]          cos_val
);

    localparam int AW_IN   = rbb_pkg::ANGLE_W;
    localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
    localparam int FULL    = 360 << ANGLE_FRAC_BITS;
    localparam longint unsigned RECIP_L = ((64'd1 << 32) + FULL - 1) / FULL;
    localparam int RCW     = $clog2(RECIP_L + 1);
    localparam int PRW     = AW_IN + RCW;
    localparam int SUMW    = AW_IN + 1;
    localparam int ADJ     = FULL - ((1 << (AW_IN - 1)) % FULL);
    localparam int R0W     = $clog2(2 * FULL);
    localparam int KW      = $clog2(QUARTER);
    localparam int AW      = $clog2(QUARTER + 1);
    localparam logic [RCW-1:0] RECIP = RCW'(RECIP_L);
    localparam logic signed [SINE_BITS:0] ONE = (SINE_BITS + 1)'(1) << (SINE_BITS - 1);

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } quad_t;

    logic [AW_IN-1:0]     u;
    logic [PRW-1:0]       prod_reg;
    logic [AW_IN-1:0]     u_reg;
    logic [R0W-1:0]       r0_reg;
    logic [SUMW-1:0]      r0_full;
    logic [2:0]           turn;
    logic [R0W-1:0]       k_full;
    quad_t                quad2_reg;
    logic [KW-1:0]        k_reg;
    quad_t                quad3_reg;
    logic [3:0]           zero_reg;
    logic [AW-1:0]        addr_a;
    logic [AW-1:0]        addr_b;
    logic [SINE_BITS-1:0] rom_a;
    logic [SINE_BITS-1:0] rom_b;
    logic signed [SINE_BITS:0] ta;
    logic signed [SINE_BITS:0] tb;
    logic signed [SINE_BITS:0] s_next;
    logic signed [SINE_BITS:0] c_next;
    logic signed [SINE_BITS:0] sin_reg;
    logic signed [SINE_BITS:0] cos_reg;

    // angle biased to unsigned; bias removed again through ADJ
    assign u = {~angle[AW_IN-1], angle[AW_IN-2:0]};

    always_comb
    begin
        r0_full = SUMW'(u_reg) + SUMW'(ADJ) - SUMW'(prod_reg[PRW-1:32] * FULL);
        turn    = 3'd0;
        for (int j = 1; j < 8; j++)
        begin
            if (r0_reg >= R0W'(j * QUARTER))
            begin
                turn = 3'(j);
            end
        end
        k_full = r0_reg - R0W'(turn) * R0W'(QUARTER);
    end

    assign addr_a = AW'(k_reg);
    assign addr_b = AW'(QUARTER) - AW'(k_reg);

    always_ff @(posedge clk)
    begin
        if (ctrl.en[rbb_pkg::ST_ACC])
        begin
            prod_reg    <= PRW'(u) * PRW'(RECIP);
            u_reg       <= u;
            zero_reg[0] <= (angle == '0);
        end
        if (ctrl.en[rbb_pkg::ST_REM])
        begin
            r0_reg      <= R0W'(r0_full);
            zero_reg[1] <= zero_reg[0];
        end
        if (ctrl.en[rbb_pkg::ST_QUAD])
        begin
            quad2_reg   <= quad_t'(turn[1:0]);
            k_reg       <= KW'(k_full);
            zero_reg[2] <= zero_reg[1];
        end
        if (ctrl.en[rbb_pkg::ST_ROM])
        begin
            quad3_reg   <= quad2_reg;
            zero_reg[3] <= zero_reg[2];
        end
        if (ctrl.en[rbb_pkg::ST_SC])
        begin
            sin_reg <= s_next;
            cos_reg <= c_next;
        end
    end

    rbb_sine_rom
    #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .SINE_BITS       (SINE_BITS)
    )
    u_rom
    (
        .clk    (clk),
        .en     (ctrl.en[rbb_pkg::ST_ROM]),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .data_a (rom_a),
        .data_b (rom_b)
    );

    // rom_a = table[k], rom_b = table[quarter - k]
    always_comb
    begin
        ta = $signed({1'b0, rom_a});
        tb = $signed({1'b0, rom_b});
        case (quad3_reg)
            QUAD_0:
            begin
                s_next = ta;
                c_next = tb;
            end
            QUAD_1:
            begin
                s_next = tb;
                c_next = -ta;
            end
            QUAD_2:
            begin
                s_next = -ta;
                c_next = -tb;
            end
            QUAD_3:
            begin
                s_next = -tb;
                c_next = ta;
            end
            default:
            begin
                s_next = ta;
                c_next = tb;
            end
        endcase
        if (zero_reg[3])
        begin
            s_next = '0;
            c_next = ONE;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

### rtl/rbb_geom.sv
// Box origin, rotated corners, bounds and output rounding.
`timescale 1ns / 1ps
module rbb_geom
#(
    parameter int COORD_FRAC_BITS = rbb_pkg::COORD_FRAC_BITS,
    parameter int SINE_BITS       = rbb_pkg::SINE_BITS
)
(
    input  logic                              clk,
    input  rbb_pkg::pipe_ctrl_t               ctrl,
    input  logic signed [rbb_pkg::POS_W-1:0]  pos_x,
    input  logic signed [rbb_pkg::POS_W-1:0]  pos_y,
    input  logic signed [rbb_pkg::OFS_W-1:0]  offset_x,
    input  logic signed [rbb_pkg::OFS_W-1:0]  offset_y,
    input  logic [rbb_pkg::SIZE_W-1:0]        size_x,
    input  logic [rbb_pkg::SIZE_W-1:0]        size_y,
    input  logic signed [SINE_BITS:0]         sin_val,
    input  logic signed [SINE_BITS:0]         cos_val,
    output rbb_pkg::result_t                  res
);

    localparam int SFRAC  = SINE_BITS - 1;
    localparam int KDIM   = 8 - COORD_FRAC_BITS + SFRAC;
    localparam int KPIX   = 8 + SFRAC;
    localparam int BASE_W = rbb_pkg::POS_W + 1;
    localparam int EXT_W  = rbb_pkg::SIZE_W + 7;
    localparam int PW     = EXT_W + SINE_BITS + 2;
    localparam int XW     = BASE_W + KDIM;
    localparam int CW     = ((XW > PW) ? XW : PW) + 2;
    localparam int SW     = CW + 1;
    localparam int RW     = CW + 2;
    localparam int DW     = rbb_pkg::DIM_W;
    localparam int EW     = rbb_pkg::CEN_W;
    localparam int PXW    = rbb_pkg::CRN_W;

    localparam logic signed [RW-1:0] HALF_D = RW'(1) <<< (KDIM - 1);
    localparam logic signed [RW-1:0] HALF_P = RW'(1) <<< (KPIX - 1);
    localparam logic signed [RW-1:0] DIM_LO = RW'(0);
    localparam logic signed [RW-1:0] DIM_HI = (RW'(1) <<< DW) - RW'(1);
    localparam logic signed [RW-1:0] CEN_HI = (RW'(1) <<< (EW - 1)) - RW'(1);
    localparam logic signed [RW-1:0] CEN_LO = -CEN_HI - RW'(1);
    localparam logic signed [RW-1:0] PIX_HI = (RW'(1) <<< (PXW - 1)) - RW'(1);
    localparam logic signed [RW-1:0] PIX_LO = -PIX_HI - RW'(1);

    function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [RW-1:0] clamp(input logic signed [RW-1:0] v,
                                                   input logic signed [RW-1:0] lo,
                                                   input logic signed [RW-1:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // halves towards plus infinity
    function automatic logic signed [RW-1:0] rnd_up(input logic signed [RW-1:0] v);
        return (v + HALF_D) >>> KDIM;
    endfunction

    // halves away from zero
    function automatic logic signed [RW-1:0] rnd_away(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] bias;
        bias = v[RW-1] ? (HALF_P - RW'(1)) : HALF_P;
        return (v + bias) >>> KPIX;
    endfunction

    logic signed [BASE_W-1:0] bx_reg [5];
    logic signed [BASE_W-1:0] by_reg [5];
    logic [EXT_W-1:0]         w_reg  [5];
    logic [EXT_W-1:0]         h_reg  [5];
    logic signed [CW-1:0]     x0_reg;
    logic signed [CW-1:0]     y0_reg;
    logic signed [PW-1:0]     wc_reg;
    logic signed [PW-1:0]     ws_reg;
    logic signed [PW-1:0]     hc_reg;
    logic signed [PW-1:0]     hs_reg;
    logic signed [CW-1:0]     cx_reg [4];
    logic signed [CW-1:0]     cy_reg [4];
    logic signed [CW-1:0]     nx_reg;
    logic signed [CW-1:0]     mx_reg;
    logic signed [CW-1:0]     ny_reg;
    logic signed [CW-1:0]     my_reg;
    logic signed [PXW-1:0]    px7_reg [4];
    logic signed [PXW-1:0]    py7_reg [4];
    logic signed [PXW-1:0]    px8_reg [4];
    logic signed [PXW-1:0]    py8_reg [4];
    logic signed [SW-1:0]     dx_reg;
    logic signed [SW-1:0]     dy_reg;
    logic signed [SW-1:0]     sx_reg;
    logic signed [SW-1:0]     sy_reg;
    logic signed [RW-1:0]     px_rnd [4];
    logic signed [RW-1:0]     py_rnd [4];
    logic signed [RW-1:0]     bw_rnd;
    logic signed [RW-1:0]     bh_rnd;
    logic signed [RW-1:0]     cenx_rnd;
    logic signed [RW-1:0]     ceny_rnd;
    rbb_pkg::result_t         res_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            px_rnd[i] = clamp(rnd_away(RW'(cx_reg[i])), PIX_LO, PIX_HI);
            py_rnd[i] = clamp(rnd_away(RW'(cy_reg[i])), PIX_LO, PIX_HI);
        end
        bw_rnd   = clamp(rnd_up(RW'(dx_reg)), DIM_LO, DIM_HI);
        bh_rnd   = clamp(rnd_up(RW'(dy_reg)), DIM_LO, DIM_HI);
        cenx_rnd = clamp(rnd_up(RW'(sx_reg)), CEN_LO, CEN_HI);
        ceny_rnd = clamp(rnd_up(RW'(sy_reg)), CEN_LO, CEN_HI);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en[rbb_pkg::ST_ACC])
        begin
            bx_reg[0] <= BASE_W'(pos_x) + BASE_W'(offset_x);
            by_reg[0] <= BASE_W'(pos_y) + BASE_W'(offset_y);
            w_reg[0]  <= EXT_W'(size_x) * EXT_W'(100);
            h_reg[0]  <= EXT_W'(size_y) * EXT_W'(100);
        end
        // stages one to four only wait for the sine lookup
        for (int i = 1; i < 5; i++)
        begin
            if (ctrl.en[i])
            begin
                bx_reg[i] <= bx_reg[i-1];
                by_reg[i] <= by_reg[i-1];
                w_reg[i]  <= w_reg[i-1];
                h_reg[i]  <= h_reg[i-1];
            end
        end
        if (ctrl.en[rbb_pkg::ST_MUL])
        begin
            x0_reg <= CW'(bx_reg[4]) <<< KDIM;
            y0_reg <= CW'(by_reg[4]) <<< KDIM;
            wc_reg <= $signed({1'b0, w_reg[4]}) * cos_val;
            ws_reg <= $signed({1'b0, w_reg[4]}) * sin_val;
            hc_reg <= $signed({1'b0, h_reg[4]}) * cos_val;
            hs_reg <= $signed({1'b0, h_reg[4]}) * sin_val;
        end
        if (ctrl.en[rbb_pkg::ST_CRN])
        begin
            cx_reg[0] <= x0_reg;
            cy_reg[0] <= y0_reg;
            cx_reg[1] <= x0_reg + CW'(wc_reg);
            cy_reg[1] <= y0_reg + CW'(ws_reg);
            cx_reg[2] <= x0_reg + CW'(wc_reg) - CW'(hs_reg);
            cy_reg[2] <= y0_reg + CW'(ws_reg) + CW'(hc_reg);
            cx_reg[3] <= x0_reg - CW'(hs_reg);
            cy_reg[3] <= y0_reg + CW'(hc_reg);
        end
        if (ctrl.en[rbb_pkg::ST_MM])
        begin
            nx_reg <= smin(smin(cx_reg[0], cx_reg[1]), smin(cx_reg[2], cx_reg[3]));
            mx_reg <= smax(smax(cx_reg[0], cx_reg[1]), smax(cx_reg[2], cx_reg[3]));
            ny_reg <= smin(smin(cy_reg[0], cy_reg[1]), smin(cy_reg[2], cy_reg[3]));
            my_reg <= smax(smax(cy_reg[0], cy_reg[1]), smax(cy_reg[2], cy_reg[3]));
            for (int i = 0; i < 4; i++)
            begin
                px7_reg[i] <= PXW'(px_rnd[i]);
                py7_reg[i] <= PXW'(py_rnd[i]);
            end
        end
        if (ctrl.en[rbb_pkg::ST_SUM])
        begin
            dx_reg <= SW'(mx_reg) - SW'(nx_reg);
            dy_reg <= SW'(my_reg) - SW'(ny_reg);
            sx_reg <= SW'(mx_reg) + SW'(nx_reg);
            sy_reg <= SW'(my_reg) + SW'(ny_reg);
            px8_reg <= px7_reg;
            py8_reg <= py7_reg;
        end
        if (ctrl.en[rbb_pkg::ST_OUT])
        begin
            res_reg.box_width  <= DW'(bw_rnd);
            res_reg.box_height <= DW'(bh_rnd);
            res_reg.center_x   <= EW'(cenx_rnd);
            res_reg.center_y   <= EW'(ceny_rnd);
            res_reg.corner0_x  <= px8_reg[0];
            res_reg.corner0_y  <= py8_reg[0];
            res_reg.corner1_x  <= px8_reg[1];
            res_reg.corner1_y  <= py8_reg[1];
            res_reg.corner2_x  <= px8_reg[2];
            res_reg.corner2_y  <= py8_reg[2];
            res_reg.corner3_x  <= px8_reg[3];
            res_reg.corner3_y  <= py8_reg[3];
        end
    end

    assign res = res_reg;

endmodule

### rtl/rbb_checker.sv
// Port-level checks on word flow of the rotated box bounds block.
`timescale 1ns / 1ps
module rbb_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rbb_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int N     = rbb_pkg::NSTAGE;
    localparam int CNT_W = $clog2(N + 2);

    logic [CNT_W-1:0] cnt_reg;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // words taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_reg + CNT_W'(in_acc) - CNT_W'(out_acc);
        end
    end

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (cnt_reg != '0))
        else $error("output word with nothing in flight");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(N))
        else $error("more words in flight than pipeline stages");

    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg < CNT_W'(N)) |-> s_axis_tready)
        else $error("input refused while a stage is free");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind rotated_box_bounds_core rbb_checker u_rbb_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
